FILE: rtl/core/bcle_pkg.sv
// ----------------------------------------------------------------------------
// bcle_pkg
// Shared request codes, cell control types and field widths of the ordered
// list engine.
// ----------------------------------------------------------------------------
package bcle_pkg;

  localparam int unsigned ValW   = 8;
  localparam int unsigned PosW   = 6;
  localparam int unsigned PivotW = 8;

  typedef enum logic [2:0] {
    REQ_READ   = 3'd0,
    REQ_HEAD   = 3'd1,
    REQ_AT_POS = 3'd2,
    REQ_SORTED = 3'd3,
    REQ_APPEND = 3'd4,
    REQ_DEL_1  = 3'd5,
    REQ_DEL_N  = 3'd6,
    REQ_DEDUP  = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [PivotW-1:0]  pivot;
    logic [ValW-1:0]    data;
  } cell_ctl_t;

endpackage

FILE: rtl/core/bcle_cell.sv
// ----------------------------------------------------------------------------
// bcle_cell
// One list slot: holds a byte and shifts toward the tail on insert or toward
// the head on delete, relative to the broadcast pivot.
// ----------------------------------------------------------------------------
module bcle_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                      clk_i,
  input  bcle_pkg::cell_ctl_t       ctl_i,
  input  logic [bcle_pkg::ValW-1:0] left_i,
  input  logic [bcle_pkg::ValW-1:0] right_i,
  output logic [bcle_pkg::ValW-1:0] value_o
);
  import bcle_pkg::*;

  localparam logic [PivotW-1:0] IdxB = PivotW'(IDX);

  logic [ValW-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    case (ctl_i.op)
      CELL_INS: begin
        if (IdxB > ctl_i.pivot) begin
          value_d = left_i;
        end else if (IdxB == ctl_i.pivot) begin
          value_d = ctl_i.data;
        end
      end
      CELL_DEL: begin
        if (IdxB >= ctl_i.pivot) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

FILE: rtl/core/bounded_char_list_engine_core.sv
// ----------------------------------------------------------------------------
// bounded_char_list_engine_core
// Ordered byte list in a row of shifting cells with a scan sequencer.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   request | start_i, busy_o        | req_type_i, elem_value_i, position_i
//   result  | result_valid_o         | ok_o, count_or_position_o,
//           |                        | read_value_o, list_length_o
//
// Read, insert at position, append and refused inserts: result one cycle
// after the transfer, busy_o stays low. Head-if-absent, sorted insert and the
// deletes scan one cell per cycle, then the result.
// Reset empties the list at once; no clearing pass.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module bounded_char_list_engine_core #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [2:0]                req_type_i,
  input  logic [bcle_pkg::ValW-1:0] elem_value_i,
  input  logic [bcle_pkg::PosW-1:0] position_i,
  output logic                      result_valid_o,
  output logic                      ok_o,
  output logic [bcle_pkg::PosW-1:0] count_or_position_o,
  output logic [bcle_pkg::ValW-1:0] read_value_o,
  output logic [bcle_pkg::PosW-1:0] list_length_o
);
  import bcle_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned W  = (CW > PosW) ? CW : PosW;

  typedef enum logic {ST_IDLE, ST_SCAN} state_e;

  state_e            state_q, state_d;
  req_e              req_q, req_d;
  logic [ValW-1:0]   val_q, val_d;
  logic [CW-1:0]     cur_q, cur_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic              valid_q, valid_d;
  logic              ok_q, ok_d;
  logic [PosW-1:0]   cop_q, cop_d;
  logic [ValW-1:0]   rd_q, rd_d;

  cell_ctl_t         ctl;
  logic [ValW-1:0]   values [CAPACITY];
  logic [CAPACITY-1:0] dup_vec;

  logic [W-1:0]      pos_w, cnt_w;
  logic              room, at_end, dup;
  logic [ValW-1:0]   cv;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ValW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = values[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = values[g+1];
    end
    bcle_cell #(.IDX(g)) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .left_i  (left),
      .right_i (right),
      .value_o (values[g])
    );
    assign dup_vec[g] = (values[g] == cv) && (CW'(g) < cur_q);
  end

  assign pos_w  = W'(position_i);
  assign cnt_w  = W'(cnt_q);
  assign room   = cnt_q < CW'(CAPACITY);
  assign at_end = cur_q == cnt_q;
  assign cv     = at_end ? '0 : values[cur_q[IW-1:0]];
  assign dup    = |dup_vec;

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    val_d     = val_q;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    valid_d   = 1'b0;
    ok_d      = ok_q;
    cop_d     = cop_q;
    rd_d      = rd_q;
    ctl.op    = CELL_HOLD;
    ctl.pivot = '0;
    ctl.data  = val_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d   = req_e'(req_type_i);
          val_d   = elem_value_i;
          cur_d   = '0;
          rem_d   = '0;
          ok_d    = 1'b0;
          cop_d   = '0;
          rd_d    = '0;
          ctl.data = elem_value_i;
          unique case (req_e'(req_type_i))
            REQ_READ: begin
              valid_d = 1'b1;
              if (pos_w >= W'(1) && pos_w <= cnt_w) begin
                ok_d = 1'b1;
                rd_d = values[IW'(pos_w - W'(1))];
              end
            end
            REQ_AT_POS: begin
              valid_d = 1'b1;
              if (room && pos_w >= W'(1) && pos_w <= cnt_w + W'(1)) begin
                ok_d      = 1'b1;
                ctl.op    = CELL_INS;
                ctl.pivot = PivotW'(pos_w - W'(1));
                cnt_d     = cnt_q + CW'(1);
              end
            end
            REQ_APPEND: begin
              valid_d = 1'b1;
              if (room) begin
                ok_d      = 1'b1;
                ctl.op    = CELL_INS;
                ctl.pivot = PivotW'(cnt_q);
                cnt_d     = cnt_q + CW'(1);
              end
            end
            REQ_HEAD, REQ_SORTED: begin
              if (room) begin
                state_d = ST_SCAN;
              end else begin
                valid_d = 1'b1;
              end
            end
            default: state_d = ST_SCAN;
          endcase
        end
      end
      ST_SCAN: begin
        case (req_q)
          REQ_HEAD: begin
            if (at_end) begin
              ctl.op  = CELL_INS;
              cnt_d   = cnt_q + CW'(1);
              ok_d    = 1'b1;
              valid_d = 1'b1;
            end else if (cv == val_q) begin
              valid_d = 1'b1;
            end else begin
              cur_d = cur_q + CW'(1);
            end
          end
          REQ_SORTED: begin
            if (at_end || cv >= val_q) begin
              ctl.op    = CELL_INS;
              ctl.pivot = PivotW'(cur_q);
              cnt_d     = cnt_q + CW'(1);
              ok_d      = 1'b1;
              valid_d   = 1'b1;
            end else begin
              cur_d = cur_q + CW'(1);
            end
          end
          REQ_DEL_1: begin
            if (at_end) begin
              valid_d = 1'b1;
            end else if (cv == val_q) begin
              ctl.op    = CELL_DEL;
              ctl.pivot = PivotW'(cur_q);
              cnt_d     = cnt_q - CW'(1);
              ok_d      = 1'b1;
              cop_d     = PosW'(W'(cur_q) + W'(1));
              valid_d   = 1'b1;
            end else begin
              cur_d = cur_q + CW'(1);
            end
          end
          REQ_DEL_N, REQ_DEDUP: begin
            if (at_end) begin
              ok_d    = (req_q == REQ_DEDUP) || (rem_q != '0);
              cop_d   = PosW'(W'(rem_q));
              valid_d = 1'b1;
            end else if ((req_q == REQ_DEL_N) ? (cv == val_q) : dup) begin
              ctl.op    = CELL_DEL;
              ctl.pivot = PivotW'(cur_q);
              cnt_d     = cnt_q - CW'(1);
              rem_d     = rem_q + CW'(1);
            end else begin
              cur_d = cur_q + CW'(1);
            end
          end
          default: valid_d = 1'b1;
        endcase
        if (valid_d) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      req_q   <= REQ_READ;
      val_q   <= '0;
      cur_q   <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
      valid_q <= 1'b0;
      ok_q    <= 1'b0;
      cop_q   <= '0;
      rd_q    <= '0;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
      val_q   <= val_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      valid_q <= valid_d;
      ok_q    <= ok_d;
      cop_q   <= cop_d;
      rd_q    <= rd_d;
    end
  end

  assign busy_o              = state_q != ST_IDLE;
  assign result_valid_o      = valid_q;
  assign ok_o                = ok_q;
  assign count_or_position_o = cop_q;
  assign read_value_o        = rd_q;
  assign list_length_o       = cnt_w[PosW-1:0];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("list length beyond capacity");
  a_cur_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cur_q <= cnt_q))
    else $error("scan cursor beyond list length");
  a_no_strobe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !result_valid_o)
    else $error("result strobe during scan");
`endif

endmodule

FILE: tb/sv/bounded_char_list_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_char_list_engine_core_tb
// Drives list requests through the start/busy port: first a directed table
// of requests, then random traffic in bursts that alternates between filling
// and draining the list. The bench mirrors the list contents and checks every
// result strobe field by field against the expected outcome: the table's own
// for typed rows, else the mirrored one.
module bounded_char_list_engine_core_tb;
  import bcle_pkg::*;

  localparam int unsigned Depth      = 32;
  localparam int unsigned NumRandom  = 1700;

  typedef struct packed {
    logic            ok;
    logic [PosW-1:0] cnt;
    logic [ValW-1:0] rd;
    logic [PosW-1:0] len;
  } outcome_t;

  typedef struct packed {
    req_e            req;
    logic [ValW-1:0] val;
    logic [PosW-1:0] pos;
    logic            typed;
    outcome_t        res;
  } req_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            start_i;
  logic            busy_o;
  logic [2:0]      req_type_i;
  logic [ValW-1:0] elem_value_i;
  logic [PosW-1:0] position_i;
  logic            result_valid_o;
  logic            ok_o;
  logic [PosW-1:0] count_or_position_o;
  logic [ValW-1:0] read_value_o;
  logic [PosW-1:0] list_length_o;

  logic [ValW-1:0] list_cells[Depth];
  int unsigned     list_len;
  outcome_t        pending_outcomes[$];
  int unsigned     mismatch_count;

  req_row_t request_table[22] = '{
    '{REQ_READ,   8'h00, 6'd1,  1'b1, '{1'b0, 6'd0, 8'h00, 6'd0}},
    '{REQ_DEL_1,  8'h11, 6'd0,  1'b1, '{1'b0, 6'd0, 8'h00, 6'd0}},
    '{REQ_DEL_N,  8'h11, 6'd0,  1'b1, '{1'b0, 6'd0, 8'h00, 6'd0}},
    '{REQ_DEDUP,  8'h00, 6'd0,  1'b1, '{1'b1, 6'd0, 8'h00, 6'd0}},
    '{REQ_APPEND, 8'h00, 6'd0,  1'b1, '{1'b1, 6'd0, 8'h00, 6'd1}},
    '{REQ_APPEND, 8'hFF, 6'd0,  1'b1, '{1'b1, 6'd0, 8'h00, 6'd2}},
    '{REQ_AT_POS, 8'h5A, 6'd0,  1'b1, '{1'b0, 6'd0, 8'h00, 6'd2}},
    '{REQ_AT_POS, 8'h5A, 6'd4,  1'b1, '{1'b0, 6'd0, 8'h00, 6'd2}},
    '{REQ_AT_POS, 8'h5A, 6'd3,  1'b1, '{1'b1, 6'd0, 8'h00, 6'd3}},
    '{REQ_HEAD,   8'hFF, 6'd0,  1'b1, '{1'b0, 6'd0, 8'h00, 6'd3}},
    '{REQ_HEAD,   8'h80, 6'd0,  1'b1, '{1'b1, 6'd0, 8'h00, 6'd4}},
    '{REQ_SORTED, 8'h7F, 6'd0,  1'b0, '0},
    '{REQ_READ,   8'h00, 6'd0,  1'b1, '{1'b0, 6'd0, 8'h00, 6'd5}},
    '{REQ_READ,   8'h00, 6'd63, 1'b1, '{1'b0, 6'd0, 8'h00, 6'd5}},
    '{REQ_READ,   8'h00, 6'd1,  1'b1, '{1'b1, 6'd0, 8'h7F, 6'd5}},
    '{REQ_APPEND, 8'hFF, 6'd0,  1'b0, '0},
    '{REQ_DEL_1,  8'hFF, 6'd0,  1'b1, '{1'b1, 6'd4, 8'h00, 6'd5}},
    '{REQ_APPEND, 8'h00, 6'd0,  1'b0, '0},
    '{REQ_DEDUP,  8'h00, 6'd0,  1'b1, '{1'b1, 6'd1, 8'h00, 6'd5}},
    '{REQ_DEL_N,  8'h7F, 6'd0,  1'b0, '0},
    '{REQ_SORTED, 8'h00, 6'd0,  1'b0, '0},
    '{REQ_READ,   8'h00, 6'd5,  1'b0, '0}
  };

  bounded_char_list_engine_core #(.CAPACITY(Depth)) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .req_type_i         (req_type_i),
    .elem_value_i       (elem_value_i),
    .position_i         (position_i),
    .result_valid_o     (result_valid_o),
    .ok_o               (ok_o),
    .count_or_position_o(count_or_position_o),
    .read_value_o       (read_value_o),
    .list_length_o      (list_length_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic outcome_t apply_request(req_e req, logic [ValW-1:0] val,
                                             logic [PosW-1:0] pos);
    outcome_t    res;
    int unsigned at;
    int unsigned kept;
    bit          room;
    bit          seen;
    res  = '0;
    room = list_len < Depth;
    at   = list_len;
    case (req)
      REQ_READ: begin
        if (pos >= 1 && pos <= list_len) begin
          res.ok = 1'b1;
          res.rd = list_cells[pos-1];
        end
      end
      REQ_HEAD, REQ_AT_POS, REQ_SORTED, REQ_APPEND: begin
        if (req == REQ_HEAD) begin
          seen = 1'b0;
          for (int i = 0; i < list_len; i++) if (list_cells[i] == val) seen = 1'b1;
          if (seen) room = 1'b0;
          at = 0;
        end else if (req == REQ_AT_POS) begin
          if (pos < 1 || pos > list_len + 1) room = 1'b0;
          at = pos - 1;
        end else if (req == REQ_SORTED) begin
          at = 0;
          while (at < list_len && list_cells[at] < val) at++;
        end
        if (room) begin
          for (int i = list_len; i > at; i--) list_cells[i] = list_cells[i-1];
          list_cells[at] = val;
          list_len++;
          res.ok = 1'b1;
        end
      end
      REQ_DEL_1: begin
        at = list_len;
        for (int i = list_len - 1; i >= 0; i--) if (list_cells[i] == val) at = i;
        if (at < list_len) begin
          for (int i = at; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
          res.ok  = 1'b1;
          res.cnt = PosW'(at + 1);
        end
      end
      REQ_DEL_N: begin
        kept = 0;
        for (int i = 0; i < list_len; i++) begin
          if (list_cells[i] != val) begin
            list_cells[kept] = list_cells[i];
            kept++;
          end
        end
        res.cnt  = PosW'(list_len - kept);
        res.ok   = (list_len != kept);
        list_len = kept;
      end
      default: begin
        kept = 0;
        for (int i = 0; i < list_len; i++) begin
          seen = 1'b0;
          for (int j = 0; j < kept; j++) if (list_cells[j] == list_cells[i]) seen = 1'b1;
          if (!seen) begin
            list_cells[kept] = list_cells[i];
            kept++;
          end
        end
        res.cnt  = PosW'(list_len - kept);
        res.ok   = 1'b1;
        list_len = kept;
      end
    endcase
    res.len = PosW'(list_len);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // hold the request until busy_o is low at a rising edge
  task automatic send_request(req_e req, logic [ValW-1:0] val, logic [PosW-1:0] pos,
                              bit typed, outcome_t typed_res);
    outcome_t res;
    start_i      <= 1'b1;
    req_type_i   <= req;
    elem_value_i <= val;
    position_i   <= pos;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    res = apply_request(req, val, pos);
    pending_outcomes.push_back(typed ? typed_res : res);
  endtask

  task automatic pause_sender(int unsigned cycles);
    if (cycles != 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (ok_o !== want.ok) report_mismatch("ok", ok_o, want.ok);
        if (count_or_position_o !== want.cnt)
          report_mismatch("count_or_position", count_or_position_o, want.cnt);
        if (read_value_o !== want.rd) report_mismatch("read_value", read_value_o, want.rd);
        if (list_length_o !== want.len)
          report_mismatch("list_length", list_length_o, want.len);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int unsigned     burst_left;
    int unsigned     fill_bias;
    int unsigned     pick;
    req_e            req;
    logic [ValW-1:0] val;
    logic [PosW-1:0] pos;
    mismatch_count = 0;
    list_len       = 0;
    fill_bias      = 70;
    burst_left     = 0;
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    req_type_i   <= '0;
    elem_value_i <= '0;
    position_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (request_table[i]) begin
      send_request(request_table[i].req, request_table[i].val, request_table[i].pos,
                   request_table[i].typed, request_table[i].res);
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 4));
    end

    for (int n = 0; n < NumRandom; n++) begin
      // swing between filling and draining phases
      if (n % 60 == 0) fill_bias = $urandom_range(0, 1) ? $urandom_range(75, 95)
                                                         : $urandom_range(10, 40);
      pick = $urandom_range(0, 99);
      if (pick < 15) req = REQ_READ;
      else if (pick < 15 + (fill_bias * 85) / 100) req = req_e'($urandom_range(1, 4));
      else req = req_e'($urandom_range(5, 7));
      case ($urandom_range(0, 2))
        0: val = ValW'($urandom_range(0, 7));
        1: val = 8'hFF - ValW'($urandom_range(0, 3));
        default: val = ValW'($urandom);
      endcase
      if ($urandom_range(0, 2) == 0) pos = PosW'($urandom_range(0, 63));
      else pos = PosW'($urandom_range(0, list_len + 1));
      send_request(req, val, pos, 1'b0, '0);
      if (burst_left == 0) begin
        pause_sender($urandom_range(0, 8));
        burst_left = $urandom_range(1, 40);
      end else begin
        burst_left--;
      end
    end
    start_i <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (Depth + 8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
